// File: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, register codes and types for the stream find-and-replace
// unit.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int MAX_PATTERN     = 8;
   localparam int MAX_REPLACEMENT = 8;
   localparam int MAX_BURST       = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                    MAX_PATTERN : MAX_REPLACEMENT;

   localparam int BYTE_W     = 8;
   localparam int BYTES_W    = 64;
   localparam int LEN_W      = 4;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_BYTES     = 2'd0,
      CSR_PATTERN_LEN       = 2'd1,
      CSR_REPLACEMENT_BYTES = 2'd2,
      CSR_REPLACEMENT_LEN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTES_W-1:0] pattern_bytes;
      logic [LEN_W-1:0]   pattern_len;
      logic [BYTES_W-1:0] replacement_bytes;
      logic [LEN_W-1:0]   replacement_len;
   } cfg_type;

   // One step's worth of result transactions, oldest in slot 0.
   typedef struct packed {
      logic [MAX_BURST-1:0][BYTE_W-1:0] bytes;
      logic [LEN_W-1:0]                 cnt;
      logic                             last;
      logic                             no_byte;
   } burst_type;

endpackage

// File: src/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register file: pattern, replacement and their lengths.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output sfr_pkg::cfg_type                 cfg
);
   import sfr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_BYTES:     cfg_in.pattern_bytes     = csr_wdata[BYTES_W-1:0];
            CSR_PATTERN_LEN:       cfg_in.pattern_len       = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES: cfg_in.replacement_bytes = csr_wdata[BYTES_W-1:0];
            CSR_REPLACEMENT_LEN:   cfg_in.replacement_len   = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes     <= '0;
         cfg_ff.pattern_len       <= LEN_W'(1);
         cfg_ff.replacement_bytes <= '0;
         cfg_ff.replacement_len   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/sfr_match_core.sv
// ----------------------------------------------------------------------------
// sfr_match_core
// Pending-byte window and the single-step match logic: works out the result
// transactions of one input byte and the window left behind.
// ----------------------------------------------------------------------------
module sfr_match_core (
   input  logic                         clock,
   input  logic                         reset,
   input  sfr_pkg::cfg_type             cfg,
   input  logic                         accept,
   input  logic [sfr_pkg::BYTE_W-1:0]   in_byte,
   input  logic                         in_last,
   output sfr_pkg::burst_type           burst
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [LEN_W-1:0]  cnt_ff;
   logic [LEN_W-1:0]  cnt_in;

   logic [BYTE_W-1:0] w [MAX_PATTERN];
   logic [LEN_W-1:0]  plen;
   logic [LEN_W-1:0]  rlen;
   logic [LEN_W-1:0]  cnt_clamped;
   logic [LEN_W-1:0]  cnt_next;
   logic [LEN_W-1:0]  drop;
   logic              match;
   logic              use_repl;
   logic [LEN_W-1:0]  n_items;

   always_comb begin
      plen = (cfg.pattern_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                    : cfg.pattern_len;
      rlen = (cfg.replacement_len > LEN_W'(MAX_REPLACEMENT)) ?
             LEN_W'(MAX_REPLACEMENT) : cfg.replacement_len;
      cnt_clamped = (cnt_ff > LEN_W'(MAX_PATTERN - 1)) ? LEN_W'(MAX_PATTERN - 1)
                                                        : cnt_ff;
      cnt_next = cnt_clamped + LEN_W'(1);

      // append the new byte behind the pending ones
      for (int i = 0; i < MAX_PATTERN; i++) begin
         w[i] = (LEN_W'(i) == cnt_clamped) ? in_byte : win_ff[i];
      end

      match = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (LEN_W'(i) < plen && w[i] != cfg.pattern_bytes[BYTE_W*i +: BYTE_W]) begin
            match = 1'b0;
         end
      end

      use_repl = 1'b0;
      if (cnt_next > plen) begin
         drop = cnt_next - plen;
      end else if (cnt_next == plen) begin
         if (match) begin
            use_repl = 1'b1;
            drop     = cnt_next;
         end else begin
            drop = LEN_W'(1);
         end
      end else begin
         drop = '0;
      end

      // the final byte flushes whatever is still pending
      if (in_last) begin
         drop = cnt_next;
      end

      n_items = use_repl ? rlen : drop;

      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_in[i] = w[i];
         for (int j = 0; j < MAX_PATTERN; j++) begin
            if (LEN_W'(j) == LEN_W'(i) + drop) begin
               win_in[i] = w[j];
            end
         end
      end
      cnt_in = cnt_next - drop;

      burst.bytes = '0;
      for (int i = 0; i < MAX_BURST; i++) begin
         if (use_repl) begin
            if (i < MAX_REPLACEMENT) begin
               burst.bytes[i] = cfg.replacement_bytes[BYTE_W*i +: BYTE_W];
            end
         end else if (i < MAX_PATTERN) begin
            burst.bytes[i] = w[i];
         end
      end
      burst.last    = in_last;
      burst.no_byte = 1'b0;
      burst.cnt     = n_items;
      if (in_last && n_items == '0) begin
         burst.no_byte  = 1'b1;
         burst.cnt      = LEN_W'(1);
         burst.bytes[0] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: src/sfr_out_buffer.sv
// ----------------------------------------------------------------------------
// sfr_out_buffer
// Result register: holds one step's burst and shifts it out one transaction
// at a time.
// ----------------------------------------------------------------------------
module sfr_out_buffer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  sfr_pkg::burst_type           burst,
   output logic                         load_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_out_last,
   output logic                         rsp_no_byte
);
   import sfr_pkg::*;

   logic [MAX_BURST-1:0][BYTE_W-1:0] slot_ff;
   logic [MAX_BURST-1:0][BYTE_W-1:0] slot_in;
   logic [LEN_W-1:0]                 cnt_ff;
   logic [LEN_W-1:0]                 cnt_in;
   logic                             last_ff;
   logic                             last_in;
   logic                             no_byte_ff;
   logic                             no_byte_in;
   logic                             pop;

   assign rsp_valid  = (cnt_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign load_ready = (cnt_ff == '0) || (cnt_ff == LEN_W'(1) && rsp_ready);

   always_comb begin
      slot_in    = slot_ff;
      cnt_in     = cnt_ff;
      last_in    = last_ff;
      no_byte_in = no_byte_ff;
      if (accept) begin
         slot_in    = burst.bytes;
         cnt_in     = burst.cnt;
         last_in    = burst.last;
         no_byte_in = burst.no_byte;
      end else if (pop) begin
         for (int i = 0; i < MAX_BURST - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
         cnt_in = cnt_ff - LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         last_ff    <= 1'b0;
         no_byte_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         last_ff    <= last_in;
         no_byte_ff <= no_byte_in;
      end
   end

   assign rsp_out_byte = slot_ff[0];
   assign rsp_out_last = last_ff && (cnt_ff == LEN_W'(1));
   assign rsp_no_byte  = no_byte_ff;

endmodule

// File: src/stream_find_and_replace_unit.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace_unit
// Streaming find-and-replace over byte strings with a configurable pattern
// and replacement.
// ----------------------------------------------------------------------------
// Bytes enter one per request transaction, with req_in_last on the final byte
// of a string. Every leftmost, non-overlapping occurrence of the pattern
// (1 to 8 bytes) is rewritten to the replacement (0 to 8 bytes); all other
// bytes come out unchanged and in order, delayed by up to pattern-length
// minus one bytes. The final response transaction of a string carries
// rsp_out_last; when a string's final step yields nothing, a single
// transaction with rsp_no_byte set (and a zero byte) ends it. A request
// transaction is taken at the first clock edge at which it is presented while
// the result register can take a new burst, and its first response
// transaction is offered in the following cycle. While rsp_ready is high,
// one byte goes in and one comes out every cycle in steady state. A byte that
// produces several response transactions (a replacement burst, or the flush
// on the final byte, at most 8) holds the input until its last one is taken,
// as the burst drains from a single result register one transaction per
// cycle while rsp_ready is high; a byte with no output does not hold up input.
// Write the configuration registers only while no string is in flight.
// ----------------------------------------------------------------------------
module stream_find_and_replace_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]       req_in_byte,
   input  logic                             req_in_last,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic                             rsp_out_last,
   output logic                             rsp_no_byte,
   // configuration write port
   input  logic                             csr_wr_en,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sfr_pkg::*;

   cfg_type   cfg;
   burst_type burst;
   logic      load_ready;
   logic      accept;

   // take a new byte when the result register is empty or is handing over
   // its final transaction in this cycle
   assign req_ready = load_ready;
   assign accept    = req_valid && load_ready;

   sfr_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // window update and match decision for the accepted byte
   sfr_match_core u_match_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .accept  (accept),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .burst   (burst)
   );

   // hold the burst and drain it towards the response channel
   sfr_out_buffer u_out_buffer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .burst        (burst),
      .load_ready   (load_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_no_byte  (rsp_no_byte)
   );

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stream find-and-replace unit. A scoreboard
// predicts the rewritten byte stream from each accepted input byte and
// compares every response transaction with the oldest expected one. A short
// directed pass and then random strings run under changing pattern and
// replacement settings and several handshake idling mixes.
// ----------------------------------------------------------------------------
class rewrite_scoreboard;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       no_byte;
   } rsp_item_type;

   logic [63:0] pat      = '0;
   logic [3:0]  pat_len  = 4'd1;
   logic [63:0] rep      = '0;
   logic [3:0]  rep_len  = '0;

   logic [7:0]  held [8];
   int unsigned held_cnt = 0;

   rsp_item_type owed [$];
   int unsigned errors   = 0;
   int unsigned checked  = 0;

   task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function int unsigned pending();
      return owed.size();
   endfunction

   function void write_register(input sfr_pkg::csr_index_type idx, input logic [63:0] val);
      case (idx)
         sfr_pkg::CSR_PATTERN_BYTES:     pat     = val;
         sfr_pkg::CSR_PATTERN_LEN:       pat_len = val[3:0];
         sfr_pkg::CSR_REPLACEMENT_BYTES: rep     = val;
         sfr_pkg::CSR_REPLACEMENT_LEN:   rep_len = val[3:0];
         default: ;
      endcase
   endfunction

   function void owe(input logic [7:0] b, input logic l, input logic nb);
      rsp_item_type it;
      it.out_byte = b;
      it.out_last = l;
      it.no_byte  = nb;
      owed = {owed, it};
   endfunction

   function void drop_oldest(input int unsigned k);
      int unsigned i;
      if (k >= held_cnt) begin
         held_cnt = 0;
         return;
      end
      for (i = 0; i + k < held_cnt; i++) held[i] = held[i + k];
      held_cnt -= k;
   endfunction

   // Work out the output transactions caused by one accepted input byte.
   function void note_byte(input logic [7:0] b, input logic last);
      int unsigned plen, rlen, surplus, i, made;
      bit          hit;
      plen = (pat_len > sfr_pkg::MAX_PATTERN) ? sfr_pkg::MAX_PATTERN : pat_len;
      rlen = (rep_len > sfr_pkg::MAX_REPLACEMENT) ? sfr_pkg::MAX_REPLACEMENT : rep_len;
      made = 0;
      if (held_cnt > 7) held_cnt = 7;
      held[held_cnt] = b;
      held_cnt++;
      if (held_cnt > plen) begin
         surplus = held_cnt - plen;
         for (i = 0; i < surplus; i++) begin
            owe(held[i], 1'b0, 1'b0);
            made++;
         end
         drop_oldest(surplus);
      end else if (held_cnt == plen) begin
         hit = 1'b1;
         for (i = 0; i < plen; i++)
            if (held[i] != pat[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (i = 0; i < rlen; i++) begin
               owe(rep[8*i +: 8], 1'b0, 1'b0);
               made++;
            end
            held_cnt = 0;
         end else begin
            owe(held[0], 1'b0, 1'b0);
            made++;
            drop_oldest(1);
         end
      end
      if (last) begin
         for (i = 0; i < held_cnt; i++) begin
            owe(held[i], 1'b0, 1'b0);
            made++;
         end
         held_cnt = 0;
         if (made == 0) owe(8'h00, 1'b1, 1'b1);
         else owed[owed.size() - 1].out_last = 1'b1;
      end
   endfunction

   task check_output(input logic [7:0] ob, input logic ol, input logic nb);
      rsp_item_type want;
      checked++;
      if (owed.size() == 0) begin
         report($sformatf("unexpected output %02h last %0b no_byte %0b", ob, ol, nb));
         return;
      end
      want = owed.pop_front();
      if (ob !== want.out_byte)
         report($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
      if (ol !== want.out_last)
         report($sformatf("out_last %0b, want %0b", ol, want.out_last));
      if (nb !== want.no_byte)
         report($sformatf("no_byte %0b, want %0b", nb, want.no_byte));
   endtask

endclass

module tb;
   import sfr_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_BYTES = 130;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  req_in_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_out_last;
   logic                  rsp_no_byte;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   rewrite_scoreboard sb = new;

   // idling odds, in percent of cycles
   int unsigned send_idle = 0;
   int unsigned rcv_idle  = 0;

   // current pattern as the string builder sees it
   logic [63:0] cur_pattern = '0;
   int unsigned eff_plen    = 1;

   int unsigned bytes_sent    = 0;
   int unsigned strings_sent  = 0;
   int unsigned settings_used = 0;
   int unsigned stall_cycles  = 0;

   stream_find_and_replace_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .rsp_no_byte  (rsp_no_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // Response side: check every accepted transaction against the oldest
   // expectation, then pick the ready level for the next cycle. Values read
   // here are the ones from before the edge, so sampling is race free.
   // The watchdog also lives here: count cycles in which neither channel
   // moves a transaction and give up once that runs too long.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_output(rsp_out_byte, rsp_out_last, rsp_no_byte);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
      rsp_ready <= ($urandom_range(99) >= rcv_idle);
   end

   // Present one byte, with random idle cycles ahead of it, and hold it until
   // the unit takes it. Valid stays high straight into the next byte when no
   // gap is drawn.
   task automatic put_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b, last);
      bytes_sent++;
      if (last) strings_sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [63:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_register(idx, val);
      @(posedge clock);
   endtask

   // Drop valid, wait for the unit to drain completely, then rewrite all four
   // registers. This is also where the sender holds off until nothing is owed.
   task automatic configure(input logic [63:0] p, input logic [3:0] pl,
                            input logic [63:0] r, input logic [3:0] rl);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(CSR_PATTERN_BYTES, p);
      write_csr(CSR_PATTERN_LEN, {60'd0, pl});
      write_csr(CSR_REPLACEMENT_BYTES, r);
      write_csr(CSR_REPLACEMENT_LEN, {60'd0, rl});
      csr_wr_en   <= 1'b0;
      cur_pattern  = p;
      eff_plen     = (pl > MAX_PATTERN) ? MAX_PATTERN : pl;
      settings_used++;
   endtask

   // Draw a setting: short patterns over a tiny alphabet so that matches are
   // common, with the zero, full and oversized lengths mixed in.
   task automatic random_configure();
      logic [63:0] p;
      logic [3:0]  pl, rl;
      int unsigned r, k;
      r = $urandom_range(99);
      if (r < 10)      pl = 4'd0;
      else if (r < 22) pl = 4'd8;
      else if (r < 30) pl = 4'($urandom_range(15, 9));
      else             pl = 4'($urandom_range(4, 1));
      if ($urandom_range(99) < 80) begin
         for (k = 0; k < 8; k++) p[8*k +: 8] = 8'h61 + 8'($urandom_range(2));
      end else begin
         p = {$urandom, $urandom};
      end
      rl = ($urandom_range(99) < 25) ? 4'd0 : 4'($urandom_range(15));
      configure(p, pl, {$urandom, $urandom}, rl);
   endtask

   // Build one string out of whole patterns, broken pattern prefixes, pattern
   // bytes and noise, and send it with the end flag on its final byte.
   task automatic send_string(input int unsigned max_len);
      logic [7:0]  s [$];
      int unsigned target, k, r, cut;
      target = $urandom_range(max_len, 1);
      while (s.size() < target) begin
         r = $urandom_range(99);
         if (r < 40 && eff_plen > 0) begin
            for (k = 0; k < eff_plen; k++) s = {s, cur_pattern[8*k +: 8]};
         end else if (r < 60 && eff_plen > 1) begin
            cut = $urandom_range(eff_plen - 1, 1);
            for (k = 0; k < cut; k++) s = {s, cur_pattern[8*k +: 8]};
         end else if (r < 80 && eff_plen > 0) begin
            s = {s, cur_pattern[8*$urandom_range(eff_plen - 1) +: 8]};
         end else begin
            s = {s, 8'($urandom)};
         end
      end
      for (k = 0; k < s.size(); k++) put_byte(s[k], k == s.size() - 1);
   endtask

   initial begin : stimulus
      int unsigned mode, k, since_cfg, per_cfg, goal;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass, no idling. Reset settings: a one-byte zero pattern
      // replaced by nothing, so a lone zero leaves a byteless end marker.
      put_byte(8'h00, 1'b1);
      put_byte(8'hFF, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(8'hFF, 1'b1);

      // oversized lengths clamp to eight: a full all-ones match
      configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd15);
      for (k = 0; k < 8; k++) put_byte(8'hFF, k == 7);

      // zero pattern length: plain pass-through
      configure(64'h0, 4'd0, {$urandom, $urandom}, 4'd8);
      put_byte(8'h5A, 1'b0);
      put_byte(8'hA5, 1'b1);

      // deletion of back-to-back matches, then a flush of a partial match
      configure(64'h0000_0000_0063_6261, 4'd3, {$urandom, $urandom}, 4'd0);
      put_byte(8'h61, 1'b0);
      put_byte(8'h62, 1'b0);
      put_byte(8'h63, 1'b0);
      put_byte(8'h61, 1'b0);
      put_byte(8'h62, 1'b0);
      put_byte(8'h63, 1'b1);
      put_byte(8'h78, 1'b0);
      put_byte(8'h61, 1'b0);
      put_byte(8'h62, 1'b1);

      // Random strings under three idling mixes, changing the setting every
      // few strings.
      for (mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle = 32; rcv_idle = 56; end
            1: begin send_idle = 56; rcv_idle = 32; end
            default: begin send_idle = 0; rcv_idle = 0; end
         endcase
         goal      = bytes_sent + RANDOM_BYTES;
         since_cfg = 0;
         per_cfg   = 0;
         while (bytes_sent < goal) begin
            if (since_cfg >= per_cfg) begin
               random_configure();
               since_cfg = 0;
               per_cfg   = $urandom_range(6, 2);
            end
            send_string(($urandom_range(9) == 0) ? 24 : 10);
            since_cfg++;
         end
      end

      // settle: let every owed transaction arrive, then a short tail
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d output transactions never arrived", sb.pending()));

      $display("run covered %0d input bytes in %0d strings over %0d settings",
               bytes_sent, strings_sent, settings_used);
      $display("%0d output transactions checked, %0d mismatches",
               sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
